/* design/lprd_pkg.sv */
// Shared types and constants for the length-prefixed request deframer.
// No dependencies; imported by the top level and the port checker.
package lprd_pkg;

    // Result classification of one byte
    typedef enum logic [1:0] {
        KIND_FRAME = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_ERROR = 2'd2,
        KIND_DROP  = 2'd3
    } t_kind_e;

    // Error codes, nonzero only on the beat that flags the error
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_TOO_LONG  = 2'd1,
        ERR_MALFORMED = 2'd2
    } t_err_e;

    localparam int unsigned LEN_W = 16;                 // length and count fields
    localparam int unsigned WORD_W = 32;                // little-endian header words
    localparam logic [LEN_W-1:0] MAX_MSG_RESET = 16'd4096;
    localparam logic [LEN_W-1:0] MIN_WORD_BYTES = 16'd4;

endpackage

/* design/length_prefixed_request_deframer_top.sv */
// Length-prefixed request deframer: byte classifier and frame parser.
// Depends on lprd_pkg (result kinds, error codes, field widths).
//
// Takes one request byte per clock and returns one result beat per byte, in order.
// A byte goes through an input register, then the combinational parser state
// update, then a result register that holds its result beat. A new byte is
// accepted every cycle as long as the result side keeps up. When the result
// side stalls, one byte waits in each register and then input ready drops.
// The parser's per-byte state update (header word assembly, body/argument/
// payload counters) sets that rate. The maximum length register is written
// through its own channel, which is always ready; write it only while no bytes
// are in flight. After the first error every byte is reported as dropped until
// reset.
module length_prefixed_request_deframer_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lprd_pkg::LEN_W-1:0] i_cfg_data,
    // input byte channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_in_byte,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output lprd_pkg::t_kind_e          o_kind,
    output logic [7:0]                 o_data_byte,
    output logic [lprd_pkg::LEN_W-1:0] o_arg_index,
    output logic                       o_arg_done,
    output logic                       o_msg_done,
    output logic [lprd_pkg::LEN_W-1:0] o_arg_count,
    output lprd_pkg::t_err_e           o_error_code
);
    import lprd_pkg::*;

    typedef enum logic [2:0] {
        PH_LEN     = 3'd0,
        PH_COUNT   = 3'd1,
        PH_ARGLEN  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_DEAD    = 3'd4
    } t_phase_e;

    // configuration
    logic [LEN_W-1:0] r_max_len;

    // input stage
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             w_adv;

    // parser state
    t_phase_e         r_phase, n_phase;
    logic [23:0]      r_word, n_word;        // first three bytes of a header word
    logic [1:0]       r_cnt, n_cnt;
    logic [LEN_W-1:0] r_body, n_body;
    logic [LEN_W-1:0] r_args, n_args;
    logic [LEN_W-1:0] r_pay, n_pay;
    logic [LEN_W-1:0] r_cur, n_cur;
    logic [LEN_W-1:0] r_total, n_total;

    // per-byte result
    t_kind_e          n_kind;
    logic [LEN_W-1:0] n_ai;
    logic             n_ad;
    logic             n_md;
    logic [LEN_W-1:0] n_ac;
    t_err_e           n_err;
    logic             w_done, w_mal, w_long;

    // result register
    logic             r_out_valid;
    t_kind_e          r_kind;
    logic [7:0]       r_data_byte;
    logic [LEN_W-1:0] r_ai;
    logic             r_ad;
    logic             r_md;
    logic [LEN_W-1:0] r_ac;
    t_err_e           r_err;

    // helper values
    logic [WORD_W-1:0] w_word;
    logic [LEN_W-1:0]  w_body_dec, w_pay_dec, w_args_dec, w_cur_inc;
    logic              w_close_last, w_close_err;

    assign w_word     = {r_in_byte, r_word};
    assign w_body_dec = r_body - 1'b1;
    assign w_pay_dec  = r_pay - 1'b1;
    assign w_args_dec = r_args - 1'b1;
    assign w_cur_inc  = r_cur + 1'b1;
    // outcome of closing an argument; body already counts the current byte
    assign w_close_last = (w_args_dec == '0);
    assign w_close_err  = w_close_last ? (w_body_dec != '0) : (w_body_dec < MIN_WORD_BYTES);

    // handshake: the parser advances whenever a byte is held and the result register can take a beat
    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_cfg_ready = 1'b1;

    // parser next state and result
    always_comb begin
        n_phase = r_phase;
        n_word  = r_word;
        n_cnt   = r_cnt;
        n_body  = r_body;
        n_args  = r_args;
        n_pay   = r_pay;
        n_cur   = r_cur;
        n_total = r_total;
        n_kind  = KIND_FRAME;
        n_ai    = '0;
        n_ad    = 1'b0;
        n_md    = 1'b0;
        n_ac    = '0;
        n_err   = ERR_NONE;
        w_done  = 1'b0;
        w_mal   = 1'b0;
        w_long  = 1'b0;

        case (r_phase)
            PH_DEAD: begin
                n_kind = KIND_DROP;
            end
            PH_PAYLOAD: begin
                n_kind = KIND_DATA;
                n_ai   = r_cur;
                n_body = w_body_dec;
                n_pay  = w_pay_dec;
                if (w_pay_dec == '0) begin
                    n_ad   = 1'b1;
                    n_args = w_args_dec;
                    n_cur  = w_cur_inc;
                    if (w_close_err) begin
                        w_mal = 1'b1;
                    end else if (w_close_last) begin
                        n_phase = PH_LEN;
                        w_done  = 1'b1;
                    end else begin
                        n_phase = PH_ARGLEN;
                    end
                end
            end
            default: begin
                // header words: frame length, argument count, argument length
                if (r_phase == PH_ARGLEN) begin
                    n_ai = r_cur;
                end
                if (r_phase != PH_LEN) begin
                    n_body = w_body_dec;
                end
                n_cnt = r_cnt + 1'b1;
                case (r_cnt)
                    2'd0: n_word[7:0]   = r_in_byte;
                    2'd1: n_word[15:8]  = r_in_byte;
                    2'd2: n_word[23:16] = r_in_byte;
                    default: begin
                        // last byte of the word: act on it
                        case (r_phase)
                            PH_LEN: begin
                                if (w_word > {16'd0, r_max_len}) begin
                                    w_long = 1'b1;
                                end else if (w_word < {16'd0, MIN_WORD_BYTES}) begin
                                    w_mal = 1'b1;
                                end else begin
                                    n_body  = w_word[LEN_W-1:0];
                                    n_phase = PH_COUNT;
                                end
                            end
                            PH_COUNT: begin
                                if (w_word > {16'd0, r_max_len}) begin
                                    w_mal = 1'b1;
                                end else begin
                                    n_total = w_word[LEN_W-1:0];
                                    n_args  = w_word[LEN_W-1:0];
                                    n_cur   = '0;
                                    if (w_word == '0) begin
                                        if (w_body_dec != '0) begin
                                            w_mal = 1'b1;
                                        end else begin
                                            n_phase = PH_LEN;
                                            w_done  = 1'b1;
                                        end
                                    end else if (w_body_dec < MIN_WORD_BYTES) begin
                                        w_mal = 1'b1;
                                    end else begin
                                        n_phase = PH_ARGLEN;
                                    end
                                end
                            end
                            default: begin
                                // argument length word
                                if (w_word > {16'd0, w_body_dec}) begin
                                    w_mal = 1'b1;
                                end else if (w_word == '0) begin
                                    // empty argument ends on its length word
                                    n_ad   = 1'b1;
                                    n_args = w_args_dec;
                                    n_cur  = w_cur_inc;
                                    if (w_close_err) begin
                                        w_mal = 1'b1;
                                    end else if (w_close_last) begin
                                        n_phase = PH_LEN;
                                        w_done  = 1'b1;
                                    end else begin
                                        n_phase = PH_ARGLEN;
                                    end
                                end else begin
                                    n_pay   = w_word[LEN_W-1:0];
                                    n_phase = PH_PAYLOAD;
                                end
                            end
                        endcase
                    end
                endcase
            end
        endcase

        // request completion and error override
        if (w_done) begin
            n_md = 1'b1;
            n_ac = n_total;
        end
        if (w_mal || w_long) begin
            n_kind  = KIND_ERROR;
            n_err   = w_long ? ERR_TOO_LONG : ERR_MALFORMED;
            n_ai    = '0;
            n_ad    = 1'b0;
            n_md    = 1'b0;
            n_ac    = '0;
            n_phase = PH_DEAD;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_MSG_RESET;
        end else if (i_cfg_valid) begin
            r_max_len <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
        end
    end

    // parser state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEN;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv) begin
            r_word      <= n_word;
            r_body      <= n_body;
            r_args      <= n_args;
            r_pay       <= n_pay;
            r_cur       <= n_cur;
            r_total     <= n_total;
            r_kind      <= n_kind;
            r_data_byte <= r_in_byte;
            r_ai        <= n_ai;
            r_ad        <= n_ad;
            r_md        <= n_md;
            r_ac        <= n_ac;
            r_err       <= n_err;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_data_byte  = r_data_byte;
    assign o_arg_index  = r_ai;
    assign o_arg_done   = r_ad;
    assign o_msg_done   = r_md;
    assign o_arg_count  = r_ac;
    assign o_error_code = r_err;

endmodule

/* design/lprd_checker.sv */
// Port-level checks for the length-prefixed request deframer.
// Depends on lprd_pkg; bound to length_prefixed_request_deframer_top below.
module lprd_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  lprd_pkg::t_kind_e          o_kind,
    input  logic [7:0]                 o_data_byte,
    input  logic [lprd_pkg::LEN_W-1:0] o_arg_index,
    input  logic                       o_arg_done,
    input  logic                       o_msg_done,
    input  logic [lprd_pkg::LEN_W-1:0] o_arg_count,
    input  lprd_pkg::t_err_e           o_error_code
);
    import lprd_pkg::*;

    logic r_dead;
    logic w_out_beat;

    assign w_out_beat = o_out_valid && i_out_ready;

    // remember that an error beat has been delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead <= 1'b0;
        end else if (w_out_beat && (o_kind == KIND_ERROR || o_kind == KIND_DROP)) begin
            r_dead <= 1'b1;
        end
    end

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_kind) && $stable(o_data_byte) && $stable(o_arg_index))
        else $error("result beat changed while stalled");

    // error code appears exactly on error beats
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_kind == KIND_ERROR) == (o_error_code != ERR_NONE)))
        else $error("error code does not match result kind");

    // once an error is reported every later beat is dropped
    a_dead_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_beat && r_dead |-> o_kind == KIND_DROP && !o_msg_done && !o_arg_done)
        else $error("byte not dropped after an error");

    // request completion only on framing or data beats, count only with it
    a_msg_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_msg_done || o_arg_count != '0) |->
            o_msg_done && (o_kind == KIND_FRAME || o_kind == KIND_DATA))
        else $error("request completion flagged on a wrong beat");

endmodule

bind length_prefixed_request_deframer_top lprd_checker u_lprd_checker (.*);

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for length_prefixed_request_deframer_top: random framed requests,
// one late malformed frame, and a byte-level predictor of every result beat.
// Depends on lprd_pkg and the deframer top level only.
module testbench;
    import lprd_pkg::*;

    // Parser phases of the predictor
    typedef enum logic [2:0] {
        S_LENGTH, S_COUNT, S_ARG_LEN, S_PAYLOAD, S_DEAD
    } t_parse_state_e;

    // What a completed word or argument decided
    typedef enum {V_NONE, V_DONE, V_BAD, V_LONG} t_verdict_e;

    // Ways to break the final frame
    typedef enum {
        F_TOO_LONG, F_SHORT_BODY, F_MANY_ARGS, F_NO_ROOM, F_ARG_OVERRUN,
        F_NEXT_NO_ROOM, F_TRAILING, F_TRAILING_EMPTY, F_LOW_LIMIT
    } t_fault_e;

    typedef struct packed {
        t_kind_e            kind;
        logic [7:0]         data;
        logic [LEN_W-1:0]   arg_idx;
        logic               arg_end;
        logic               msg_end;
        logic [LEN_W-1:0]   arg_cnt;
        t_err_e             err;
    } t_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [LEN_W-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic [7:0]         i_in_byte = '0;
    logic               i_out_ready = 1'b0;
    logic               o_cfg_ready;
    logic               o_in_ready;
    logic               o_out_valid;
    t_kind_e            o_kind;
    logic [7:0]         o_data_byte;
    logic [LEN_W-1:0]   o_arg_index;
    logic               o_arg_done;
    logic               o_msg_done;
    logic [LEN_W-1:0]   o_arg_count;
    t_err_e             o_error_code;

    length_prefixed_request_deframer_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_data_byte  (o_data_byte),
        .o_arg_index  (o_arg_index),
        .o_arg_done   (o_arg_done),
        .o_msg_done   (o_msg_done),
        .o_arg_count  (o_arg_count),
        .o_error_code (o_error_code)
    );

    // Predictor state
    logic [LEN_W-1:0]   msg_limit = MAX_MSG_RESET;
    t_parse_state_e     pstate = S_LENGTH;
    logic [31:0]        word_acc = '0;
    logic [1:0]         word_pos = '0;
    logic [LEN_W-1:0]   body_left = '0;
    logic [LEN_W-1:0]   args_left = '0;
    logic [LEN_W-1:0]   payload_left = '0;
    logic [LEN_W-1:0]   arg_cur = '0;
    logic [LEN_W-1:0]   arg_total = '0;

    // Bench bookkeeping
    logic [7:0] byte_queue[$];
    t_beat      expected_beats[$];
    int         bytes_queued = 0;
    int         bytes_taken = 0;
    int         fail_count = 0;
    bit         rst_done = 1'b0;
    bit         in_beat = 1'b0;
    bit         calm = 1'b0;
    int         hold_kick = 0;
    int         hold_seen = 0;
    int         hold_left = 0;

    initial forever #1 i_clk = ~i_clk;

    // An argument just ended: decide whether more follow, the request is done, or it is bad
    function automatic t_verdict_e end_of_arg();
        args_left = args_left - 1'b1;
        arg_cur = arg_cur + 1'b1;
        if (args_left == 0) begin
            if (body_left != 0) return V_BAD;
            pstate = S_LENGTH;
            return V_DONE;
        end
        if (body_left < MIN_WORD_BYTES) return V_BAD;
        pstate = S_ARG_LEN;
        return V_NONE;
    endfunction

    // Advance the parser by one byte and return the beat it must produce
    function automatic t_beat parse_byte(input logic [7:0] b);
        t_beat      r;
        t_verdict_e v;
        logic [31:0] w;
        r = '0;
        r.data = b;
        v = V_NONE;
        if (pstate == S_DEAD) begin
            r.kind = KIND_DROP;
        end else if (pstate == S_PAYLOAD) begin
            r.kind = KIND_DATA;
            r.arg_idx = arg_cur;
            body_left = body_left - 1'b1;
            payload_left = payload_left - 1'b1;
            if (payload_left == 0) begin
                r.arg_end = 1'b1;
                v = end_of_arg();
            end
        end else begin
            r.kind = KIND_FRAME;
            if (pstate == S_ARG_LEN) r.arg_idx = arg_cur;
            if (pstate != S_LENGTH) body_left = body_left - 1'b1;
            word_acc = word_acc | ({24'b0, b} << (8 * word_pos));
            if (word_pos != 2'd3) begin
                word_pos = word_pos + 1'b1;
            end else begin
                w = word_acc;
                word_pos = '0;
                word_acc = '0;
                case (pstate)
                    S_LENGTH: begin
                        if (w > msg_limit) v = V_LONG;
                        else if (w < MIN_WORD_BYTES) v = V_BAD;
                        else begin
                            body_left = w[LEN_W-1:0];
                            pstate = S_COUNT;
                        end
                    end
                    S_COUNT: begin
                        if (w > msg_limit) begin
                            v = V_BAD;
                        end else begin
                            arg_total = w[LEN_W-1:0];
                            args_left = arg_total;
                            arg_cur = '0;
                            if (w == 0) begin
                                if (body_left != 0) v = V_BAD;
                                else begin
                                    pstate = S_LENGTH;
                                    v = V_DONE;
                                end
                            end else if (body_left < MIN_WORD_BYTES) begin
                                v = V_BAD;
                            end else begin
                                pstate = S_ARG_LEN;
                            end
                        end
                    end
                    default: begin
                        if (w > body_left) begin
                            v = V_BAD;
                        end else if (w == 0) begin
                            r.arg_end = 1'b1;
                            v = end_of_arg();
                        end else begin
                            payload_left = w[LEN_W-1:0];
                            pstate = S_PAYLOAD;
                        end
                    end
                endcase
            end
        end
        if (v == V_DONE) begin
            r.msg_end = 1'b1;
            r.arg_cnt = arg_total;
        end else if (v == V_BAD || v == V_LONG) begin
            r.kind = KIND_ERROR;
            r.err = (v == V_LONG) ? ERR_TOO_LONG : ERR_MALFORMED;
            r.arg_idx = '0;
            r.arg_end = 1'b0;
            r.msg_end = 1'b0;
            r.arg_cnt = '0;
            pstate = S_DEAD;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Monitor: predict on every input beat, compare every result beat
    always @(posedge i_clk) begin : monitor
        t_beat want;
        in_beat = i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (in_beat) begin
                expected_beats = {expected_beats, parse_byte(i_in_byte)};
                bytes_taken++;
                calm = (bytes_taken >= 400 && bytes_taken < 650);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected, data_byte %0h", o_data_byte);
                    fail_count++;
                end else begin
                    want = expected_beats.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("data_byte", want.data, o_data_byte);
                    check_field("arg_index", want.arg_idx, o_arg_index);
                    check_field("arg_done", want.arg_end, o_arg_done);
                    check_field("msg_done", want.msg_end, o_msg_done);
                    check_field("arg_count", want.arg_cnt, o_arg_count);
                    check_field("error_code", want.err, o_error_code);
                end
            end
        end
    end

    // Byte driver: holds each beat until taken, idles now and then
    always @(negedge i_clk) begin : byte_driver
        if (!i_in_valid || in_beat) begin
            if (rst_done && byte_queue.size() != 0 && (calm || $urandom_range(99) >= 13)) begin
                i_in_valid <= 1'b1;
                i_in_byte <= byte_queue.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random backpressure plus one long hold-off on request
    always @(negedge i_clk) begin : receiver
        if (hold_kick != hold_seen) begin
            hold_seen = hold_kick;
            hold_left = 150;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= 13);
        end
    end

    task automatic push_byte(input logic [7:0] b);
        byte_queue = {byte_queue, b};
        bytes_queued++;
    endtask

    // Header words go out little-endian
    task automatic push_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++) push_byte(w[8*k +: 8]);
    endtask

    task automatic push_payload(input int unsigned n);
        repeat (n) push_byte(8'($urandom));
    endtask

    // Well-formed request: nargs arguments sharing pay_total payload bytes
    task automatic queue_request(input int unsigned nargs, input int unsigned pay_total);
        int unsigned left;
        int unsigned len;
        left = pay_total;
        push_word(4 + 4 * nargs + pay_total);
        push_word(nargs);
        for (int a = 0; a < nargs; a++) begin
            if (a == nargs - 1) len = left;
            else if ($urandom_range(3) == 0) len = 0;
            else len = $urandom_range(left, 0);
            left -= len;
            push_word(len);
            push_payload(len);
        end
    endtask

    // Random well-formed request that fits the current limit
    task automatic queue_random_request();
        int unsigned n;
        int unsigned p;
        int unsigned room;
        case ($urandom_range(9))
            0: n = 0;
            1, 2: n = $urandom_range(12, 5);
            default: n = $urandom_range(4, 1);
        endcase
        if (4 + 4 * n > msg_limit) n = (msg_limit - 4) / 4;
        room = msg_limit - 4 - 4 * n;
        if (n == 0) p = 0;
        else if ($urandom_range(7) == 0 && room <= 300) p = room;  // body right at the limit
        else p = $urandom_range((room < 40) ? room : 40, 0);
        queue_request(n, p);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (byte_queue.size() != 0 || i_in_valid || expected_beats.size() != 0);
    endtask

    task automatic write_max_len(input logic [LEN_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        msg_limit = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One broken frame; the block is dead afterwards, so this runs once at the end
    task automatic queue_broken_request();
        t_fault_e       f;
        int unsigned    p;
        int unsigned    t;
        f = t_fault_e'($urandom_range(int'(F_LOW_LIMIT)));
        p = $urandom_range(12);
        t = $urandom_range(3, 1);
        case (f)
            F_TOO_LONG: begin
                if ($urandom_range(1) == 0) push_word(msg_limit + 1 + $urandom_range(50));
                else push_word({8'($urandom_range(255, 1)), 24'($urandom)});
            end
            F_SHORT_BODY: push_word($urandom_range(3));
            F_MANY_ARGS: begin
                push_word(msg_limit);
                push_word(msg_limit + 1 + $urandom_range(1000));
            end
            // argument due but fewer than four body bytes after the count
            F_NO_ROOM: begin
                push_word(4 + t);
                push_word(1);
            end
            F_ARG_OVERRUN: begin
                push_word(8 + p);
                push_word(1);
                push_word(p + t);
            end
            // second argument due but its length word cannot fit
            F_NEXT_NO_ROOM: begin
                push_word(8 + p + t);
                push_word(2);
                push_word(p);
                push_payload(p);
            end
            F_TRAILING: begin
                push_word(8 + p + t);
                push_word(1);
                push_word(p);
                push_payload(p);
            end
            F_TRAILING_EMPTY: begin
                push_word(4 + t);
                push_word(0);
            end
            default: begin
                // limit below four: even the smallest body is too long
                wait_idle();
                write_max_len(LEN_W'($urandom_range(3)));
                push_word(4);
                push_word(0);
            end
        endcase
    endtask

    // Stimulus
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        // Directed: empty request, one empty argument, one all-ones data byte
        queue_request(0, 0);
        queue_request(1, 0);
        push_word(9);
        push_word(1);
        push_word(1);
        push_byte(8'hFF);
        wait_idle();

        // Lowest legal limit: only four-byte bodies fit
        write_max_len(16'd4);
        repeat (3) queue_random_request();
        wait_idle();

        // Highest limit, one long body
        write_max_len(16'hFFFF);
        queue_request(2, 200);
        repeat (4) queue_random_request();
        wait_idle();

        // Small random limit, receiver holds off while bytes keep coming
        write_max_len(LEN_W'($urandom_range(300, 20)));
        hold_kick++;
        repeat (12) queue_random_request();
        wait_idle();

        write_max_len(MAX_MSG_RESET);
        while (bytes_queued < 1000) begin
            queue_random_request();
            if ($urandom_range(11) == 0) begin
                wait_idle();
                if ($urandom_range(1) == 0) write_max_len(LEN_W'($urandom_range(65535, 4)));
            end
        end
        wait_idle();

        write_max_len(MAX_MSG_RESET);
        queue_random_request();
        queue_broken_request();
        push_payload(40);
        wait_idle();
        repeat (10) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("PASS length_prefixed_request_deframer_top");
        end else begin
            $display("FAIL length_prefixed_request_deframer_top");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("FAIL length_prefixed_request_deframer_top");
        $finish;
    end

endmodule
